### hdl/rfis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfis_pkg: shared types and constants
// controller commands, datapath status and widths for the factor search
// ----------------------------------------------------------------------------
package rfis_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned WideW = 64;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SQRT  = 4'd2,
    OP_TRIAL = 4'd3,
    OP_DIV   = 4'd4,
    OP_NEXT  = 4'd5,
    OP_PHI   = 4'd6,
    OP_EGINI = 4'd7,
    OP_EGDIV = 4'd8,
    OP_EGUPD = 4'd9,
    OP_FIN   = 4'd10
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic trial_end;
    logic divides;
    logic phi_small;
    logic eg_done;
  } dp_stat_t;

endpackage

### hdl/rfis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfis_req_if / rfis_rsp_if: request and result channels
// valid/ready handshake carrying the payload fields
// ----------------------------------------------------------------------------
interface rfis_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] modulus;
  logic [31:0] exponent;
  modport source (output valid, output modulus, output exponent, input ready);
  modport sink (input valid, input modulus, input exponent, output ready);
endinterface

interface rfis_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] factor_small;
  logic [31:0] factor_large;
  logic [31:0] inverse;
  logic        factor_found;
  modport source (output valid, output factor_small, output factor_large,
                  output inverse, output factor_found, input ready);
  modport sink (input valid, input factor_small, input factor_large,
                input inverse, input factor_found, output ready);
endinterface

### hdl/rsa_factor_and_inverse_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_factor_and_inverse_search_unit: trial factoring and inverse search
// factors the modulus by odd trial division and finds exponent^-1 mod phi
// ----------------------------------------------------------------------------
// in channel: one request carries modulus and exponent; ready is high only
//   while the unit is idle, so one request is worked on at a time
// out channel: one result per request, held stable until the receiver takes it
// sequence: a load and a bit-serial square root, then for each trial divisor
//   a test, a serial division and a check, scanning down from the root; the
//   first divisor that divides ends the scan
//   the inverse is found by extended euclid, each step a serial division, an
//   update and a check, about 48 steps at most for 32-bit phi
//   worst case is 32767 trial divisions
// throughput: the next request is taken the cycle after the result leaves
// reset: synchronous active-low rst_n returns the sequencer to idle, no
//   result pending
// stall: a result waits in the output register while out_ready is low and
//   no request is taken until it is accepted
// ----------------------------------------------------------------------------
module rsa_factor_and_inverse_search_unit #(
  parameter int unsigned MODULUS_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  rfis_req_if.sink   in_req,
  rfis_rsp_if.source out_rsp
);
  import rfis_pkg::*;

  dp_cmd_t  cmd_main;
  dp_stat_t stat;
  logic     idle;
  logic     out_pend;
  logic     in_fire;
  logic     out_fire;

  assign in_req.ready = idle;
  assign in_fire  = in_req.valid && idle;
  assign out_fire = out_rsp.valid && out_rsp.ready;
  assign out_rsp.valid = out_pend;

  rfis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_fire (out_fire),
    .stat     (stat),
    .cmd      (cmd_main),
    .idle     (idle),
    .busy_out (out_pend)
  );

  rfis_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_main),
    .modulus  (in_req.modulus),
    .exponent (in_req.exponent),
    .stat     (stat),
    .p_o      (out_rsp.factor_small),
    .q_o      (out_rsp.factor_large),
    .inv_o    (out_rsp.inverse),
    .found_o  (out_rsp.factor_found)
  );

  // never accept a new request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_pend |-> !in_fire) else $error("request taken while result pending");

  // after a request is taken the unit is busy
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !idle) else $error("unit idle right after request");

  // result leaves only through a handshake
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pend && !out_rsp.ready) |=> out_pend) else $error("result dropped");
endmodule

### hdl/rfis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfis_datapath: factor search and inverse datapath
// bit-serial square root and divider, trial scan and extended euclid
// ----------------------------------------------------------------------------
module rfis_datapath #(
  parameter int unsigned MODULUS_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rfis_pkg::dp_cmd_t       cmd,
  input  logic [31:0]             modulus,
  input  logic [31:0]             exponent,
  output rfis_pkg::dp_stat_t      stat,
  output logic [31:0]             p_o,
  output logic [31:0]             q_o,
  output logic [31:0]             inv_o,
  output logic                    found_o
);
  import rfis_pkg::*;

  localparam logic [31:0] NMask = (MODULUS_BITS >= 32) ? 32'hFFFF_FFFF
                                  : ((32'd1 << MODULUS_BITS) - 32'd1);

  logic [31:0] n_r, n_nxt;
  logic [31:0] e_r, e_nxt;
  logic [31:0] i_r, i_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] q_r, q_nxt;
  logic        found_r, found_nxt;
  // shared serial divider: num / den
  logic [63:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  // square root
  logic [31:0] sq_x_r, sq_x_nxt;
  logic [33:0] sq_rem_r, sq_rem_nxt;
  logic [15:0] sq_root_r, sq_root_nxt;
  // euclid state
  logic [63:0] phi_r, phi_nxt;
  logic [63:0] or_r, or_nxt, r_r, r_nxt;
  logic signed [65:0] os_r, os_nxt, s_r, s_nxt;
  logic        eg_first_r, eg_first_nxt;
  logic [31:0] inv_r, inv_nxt;

  logic [64:0] rem_sh;
  logic [33:0] sq_trial;
  logic [33:0] sq_sh;
  logic signed [65:0] qs_prod;
  logic signed [65:0] os_fix;

  always_comb begin
    rem_sh   = {rem_r, num_r[63]};
    sq_sh    = {sq_rem_r[31:0], sq_x_r[31:30]};
    sq_trial = {16'd0, sq_root_r, 2'b01};
    // quotient and cofactor both stay below phi, so 33 by 33 bits is enough
    qs_prod  = $signed({1'b0, quo_r[31:0]}) * $signed(s_r[32:0]);
    os_fix   = os_r + $signed({2'b00, phi_r});

    n_nxt = n_r; e_nxt = e_r; i_nxt = i_r; p_nxt = p_r; q_nxt = q_r;
    found_nxt = found_r; num_nxt = num_r; den_nxt = den_r; quo_nxt = quo_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; sq_x_nxt = sq_x_r; sq_rem_nxt = sq_rem_r;
    sq_root_nxt = sq_root_r; phi_nxt = phi_r; or_nxt = or_r; r_nxt = r_r;
    os_nxt = os_r; s_nxt = s_r; inv_nxt = inv_r; eg_first_nxt = eg_first_r;

    case (cmd.op)
      OP_LOAD: begin
        n_nxt = modulus & NMask;
        e_nxt = exponent;
        sq_x_nxt = modulus & NMask;
        sq_rem_nxt = '0;
        sq_root_nxt = '0;
        cnt_nxt = 7'd0;
        p_nxt = '0; q_nxt = '0; found_nxt = 1'b0; inv_nxt = '0; phi_nxt = '0;
      end
      OP_SQRT: begin
        sq_x_nxt = {sq_x_r[29:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          sq_rem_nxt  = sq_sh - sq_trial;
          sq_root_nxt = {sq_root_r[14:0], 1'b1};
        end else begin
          sq_rem_nxt  = sq_sh;
          sq_root_nxt = {sq_root_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        i_nxt = {17'd0, sq_root_nxt[15:1]};
      end
      OP_TRIAL: begin
        num_nxt = {n_r, 32'd0};
        den_nxt = {31'd0, i_r, 1'b1};
        rem_nxt = '0; quo_nxt = '0;
        cnt_nxt = 7'd32;
      end
      OP_EGDIV: begin
        num_nxt = or_r;
        den_nxt = r_r;
        rem_nxt = '0; quo_nxt = '0;
        cnt_nxt = 7'd0;
      end
      OP_DIV: begin
        num_nxt = {num_r[62:0], 1'b0};
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = 64'(rem_sh - {1'b0, den_r});
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
      end
      OP_NEXT: i_nxt = i_r - 32'd1;
      OP_PHI: begin
        p_nxt = den_r[31:0];
        q_nxt = quo_r[31:0];
        found_nxt = 1'b1;
        phi_nxt = 64'(den_r[31:0] - 32'd1) * 64'(quo_r[31:0] - 32'd1);
      end
      OP_EGINI: begin
        num_nxt = {32'd0, e_r};
        den_nxt = phi_r;
        rem_nxt = '0; quo_nxt = '0;
        cnt_nxt = 7'd0;
        or_nxt = '0; r_nxt = phi_r;
        os_nxt = 66'sd1; s_nxt = '0;
        eg_first_nxt = 1'b1;
      end
      OP_EGUPD: begin
        if (eg_first_r) begin
          or_nxt = rem_r;
          eg_first_nxt = 1'b0;
        end else begin
          or_nxt = r_r;
          r_nxt  = rem_r;
          os_nxt = s_r;
          s_nxt  = os_r - qs_prod;
        end
      end
      OP_FIN: begin
        if (or_r == 64'd1)
          inv_nxt = (os_r < 0) ? os_fix[31:0] : os_r[31:0];
        else
          inv_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; e_r <= e_nxt; i_r <= i_nxt; p_r <= p_nxt; q_r <= q_nxt;
    num_r <= num_nxt; den_r <= den_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    sq_x_r <= sq_x_nxt; sq_rem_r <= sq_rem_nxt; sq_root_r <= sq_root_nxt;
    phi_r <= phi_nxt; or_r <= or_nxt; r_r <= r_nxt; os_r <= os_nxt; s_r <= s_nxt;
    inv_r <= inv_nxt; eg_first_r <= eg_first_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      found_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      found_r <= found_nxt;
    end
  end

  // first euclid step swaps in e mod phi; the loop then runs until r is zero
  assign stat.sqrt_done = (cnt_r == 7'd15);
  assign stat.div_done  = (cnt_r == 7'd63);
  assign stat.trial_end = (i_r == 32'd0);
  assign stat.divides   = (rem_r == 64'd0);
  assign stat.phi_small = (phi_r < 64'd2);
  assign stat.eg_done   = (r_r == 64'd0);

  assign p_o = p_r;
  assign q_o = q_r;
  assign inv_o = inv_r;
  assign found_o = found_r;
endmodule

### hdl/rfis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfis_ctrl: sequencing state machine
// steps the datapath through root, trial scan, phi and euclid loop
// ----------------------------------------------------------------------------
module rfis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  input  rfis_pkg::dp_stat_t stat,
  output rfis_pkg::dp_cmd_t  cmd,
  output logic               idle,
  output logic               busy_out
);
  import rfis_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQRT  = 10'b0000000010,
    S_TEST  = 10'b0000000100,
    S_TDIV  = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_PHI   = 10'b0000100000,
    S_EGLP  = 10'b0001000000,
    S_EGUPD = 10'b0010000000,
    S_EGCHK = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (stat.sqrt_done) state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.trial_end) state_nxt = S_OUT;
        else begin
          cmd.op = OP_TRIAL;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd.op = OP_DIV;
        if (stat.div_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.divides) begin
          cmd.op = OP_PHI;
          state_nxt = S_PHI;
        end else begin
          cmd.op = OP_NEXT;
          state_nxt = S_TEST;
        end
      end
      S_PHI: begin
        if (stat.phi_small) state_nxt = S_OUT;
        else begin
          cmd.op = OP_EGINI;
          state_nxt = S_EGLP;
        end
      end
      S_EGLP: begin
        cmd.op = OP_DIV;
        if (stat.div_done) state_nxt = S_EGUPD;
      end
      S_EGUPD: begin
        cmd.op = OP_EGUPD;
        state_nxt = S_EGCHK;
      end
      // after an update either divide again or finish
      S_EGCHK: begin
        if (stat.eg_done) begin
          cmd.op = OP_FIN;
          state_nxt = S_OUT;
        end else begin
          cmd.op = OP_EGDIV;
          state_nxt = S_EGLP;
        end
      end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign busy_out = (state_r == S_OUT);
endmodule

### test/rfis_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfis_result_checker: result predictor and scoreboard
// watches both channels, computes the factors and inverse for every accepted
// request and compares each accepted result against the oldest prediction
// ----------------------------------------------------------------------------
module rfis_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  rfis_req_if        req,
  rfis_rsp_if        rsp,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [31:0] factor_small;
    logic [31:0] factor_large;
    logic [31:0] inverse;
    logic        factor_found;
  } factor_result_t;

  factor_result_t expected_results[$];

  function automatic logic [31:0] root_floor(input logic [31:0] n);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (64'(mid) * 64'(mid) <= 64'(n)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // extended euclid, unique inverse in [1, m) or 0
  function automatic logic [31:0] inverse_mod(input longint a, input longint m);
    longint old_r;
    longint r;
    longint old_s;
    longint s;
    longint qt;
    longint t;
    if (m < 2) return 0;
    old_r = a % m;
    r     = m;
    old_s = 1;
    s     = 0;
    while (r != 0) begin
      qt = old_r / r;
      t = old_r - qt * r; old_r = r; r = t;
      t = old_s - qt * s; old_s = s; s = t;
    end
    if (old_r != 1) return 0;
    if (old_s < 0) old_s += m;
    return 32'(old_s % m);
  endfunction

  function automatic factor_result_t factor_and_invert(input logic [31:0] n,
                                                       input logic [31:0] e);
    factor_result_t res;
    logic [31:0]    d;
    longint         phi;
    res = '0;
    // scan odd divisors downward from the root, first hit is the largest
    for (int unsigned i = root_floor(n) / 2; i >= 1; i--) begin
      d = 2 * i + 1;
      if (n % d == 0) begin
        res.factor_small = d;
        res.factor_large = n / d;
        res.factor_found = 1'b1;
        break;
      end
    end
    if (res.factor_found) begin
      phi = longint'(res.factor_small - 1) * longint'(res.factor_large - 1);
      res.inverse = inverse_mod(longint'(e), phi);
    end
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    factor_result_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(factor_and_invert(req.modulus, req.exponent));
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: %h %h %h %b", rsp.factor_small,
                     rsp.factor_large, rsp.inverse, rsp.factor_found);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.factor_small !== rsp.factor_small ||
              want.factor_large !== rsp.factor_large ||
              want.inverse !== rsp.inverse ||
              want.factor_found !== rsp.factor_found) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                       want.factor_small, want.factor_large, want.inverse,
                       want.factor_found, rsp.factor_small, rsp.factor_large,
                       rsp.inverse, rsp.factor_found);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### test/rsa_factor_and_inverse_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_factor_and_inverse_search_unit_tb: factor search testbench
// directed corner requests, then random requests under several idle and
// stall mixes, with a long receiver hold and a full drain between phases
// ----------------------------------------------------------------------------
module rsa_factor_and_inverse_search_unit_tb;

  localparam int WatchdogLimit = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_token;
  int   hold_seen;
  int   hold_left;
  int   quiet_cycles;

  rfis_req_if in_req ();
  rfis_rsp_if out_rsp ();

  rsa_factor_and_inverse_search_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  rfis_result_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .rsp       (out_rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold whenever the token moves
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= 3000;
      out_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_request(input logic [31:0] n, input logic [31:0] e);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.modulus  <= n;
    in_req.exponent <= e;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic drain;
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random;
    logic [31:0] n;
    logic [31:0] e;
    logic [31:0] a;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      n = $urandom_range(65535, 9);
    end else if (pick < 90) begin
      // near-square product: large modulus, divisor found close to the root
      a = $urandom_range(65535, 32768) | 32'd1;
      n = a * $urandom_range(a + 2000 > 65535 ? 65535 : a + 2000, a);
    end else if (pick < 95) begin
      n = $urandom_range(8);
    end else begin
      n = $urandom_range(32'hFFFFFF);
    end
    e = $urandom_range(1) ? ($urandom_range(65535) | 32'd1) : $urandom;
    send_request(n, e);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_req.valid   <= 1'b0;
    in_req.modulus <= '0;
    in_req.exponent <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_request(32'd0, 32'd0);                 // no divisor at all
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF); // all ones, divisor at the root
    send_request(32'd8, 32'd3);                 // 3 is tried but does not divide
    send_request(32'd9, 32'd3);                 // smallest hit, p = q = 3
    send_request(32'd15, 32'd7);
    send_request(32'd15, 32'd2);                // exponent shares a factor with phi
    send_request(32'd15, 32'd0);                // zero exponent
    send_request(32'd15, 32'hFFFF_FFFF);        // exponent above phi
    send_request(32'd25, 32'd3);
    send_request(32'd30, 32'd7);                // even modulus, odd divisor
    send_request(32'd35, 32'd5);
    send_request(32'd3233, 32'd17);
    send_request(32'd97, 32'd5);                // prime, full scan
    send_request(32'd65521, 32'd3);             // 16-bit prime
    send_request(32'd65533 * 32'd65535, 32'd65537);
    send_request(32'd32769 * 32'd32771, 32'h8000_0001);
    send_request(32'd1024, 32'd1);              // power of two, no odd divisor
    send_request(32'd21, 32'd1);
    drain();

    // long receiver hold while requests keep coming
    hold_token = hold_token + 1;
    repeat (6) send_request($urandom_range(4000, 9), $urandom);
    drain();

    // idle mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 79) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 79) : 0;
      repeat (25) send_random();
      drain();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
